// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg: shared definitions for the complex arithmetic unit
// Holds default widths and the operation codes.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned FracBitsDef  = 8;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

endpackage

// ===== rtl/cau_div_lane.sv =====
// ----------------------------------------------------------------------------
// cau_div_lane: pipelined unsigned restoring divider
// One quotient bit per stage; flags quotients that do not fit QW bits.
// ----------------------------------------------------------------------------
module cau_div_lane #(
  parameter int unsigned NW   = 40,
  parameter int unsigned DENW = 32,
  parameter int unsigned QW   = 17
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NW-1:0]   num_i,
  input  logic [DENW-1:0] den_i,
  output logic [QW-1:0]   quo_o,
  output logic            ovf_o
);
  import cau_pkg::*;

  localparam int unsigned EW = NW + DENW + QW;

  logic [NW-1:0]   r_in  [QW];
  logic [DENW-1:0] d_in  [QW];
  logic [QW-1:0]   q_in  [QW];
  logic            o_in  [QW];
  logic [NW-1:0]   r_q   [QW];
  logic [DENW-1:0] d_q   [QW];
  logic [QW-1:0]   q_q   [QW];
  logic            o_q   [QW];

  assign r_in[0] = num_i;
  assign d_in[0] = den_i;
  assign q_in[0] = '0;
  // quotient too large for QW bits when num >= den * 2^QW
  assign o_in[0] = (EW'(num_i) >= (EW'(den_i) << QW));

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int unsigned K = QW - 1 - i;
    logic [EW-1:0]   trial;
    logic            ge;
    logic [NW-1:0]   r_d;
    logic [QW-1:0]   q_d;

    if (i > 0) begin : g_link
      assign r_in[i] = r_q[i-1];
      assign d_in[i] = d_q[i-1];
      assign q_in[i] = q_q[i-1];
      assign o_in[i] = o_q[i-1];
    end

    always_comb begin
      trial = EW'(d_in[i]) << K;
      ge    = (EW'(r_in[i]) >= trial);
      r_d   = ge ? NW'(EW'(r_in[i]) - trial) : r_in[i];
      q_d   = q_in[i] | (QW'(ge) << K);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i] <= r_d;
        d_q[i] <= d_in[i];
        q_q[i] <= q_d;
        o_q[i] <= o_in[i];
      end
    end
  end

  assign quo_o = q_q[QW-1];
  assign ovf_o = o_q[QW-1];

endmodule

// ===== rtl/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit: complex add, subtract, multiply and divide
// Fixed-point complex operations with saturation and divide-by-zero flag.
// ----------------------------------------------------------------------------
// Path: stage 1 and stage 2 registers, the divider stages, then the output register.
// Throughput: one word per cycle; the pipe advances as a whole whenever the
//   output register is empty or being taken, so a stall freezes every stage.
// Depth is set by the restoring divider, one quotient bit per stage.
// Reset: clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module complex_arith_unit #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = cau_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  cau_pkg::op_e                 req_type_i,
  input  logic signed [DATA_WIDTH-1:0] a_real_i,
  input  logic signed [DATA_WIDTH-1:0] a_imag_i,
  input  logic signed [DATA_WIDTH-1:0] b_real_i,
  input  logic signed [DATA_WIDTH-1:0] b_imag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] res_real_o,
  output logic signed [DATA_WIDTH-1:0] res_imag_o,
  output logic                         div_zero_o,
  output logic                         sat_flag_o
);
  import cau_pkg::*;

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned PW   = 2 * DW;              // one product
  localparam int unsigned SW   = 2 * DW + 1;          // sum of two products
  localparam int unsigned NW   = 2 * DW + FRAC_BITS;  // dividend magnitude
  localparam int unsigned DENW = 2 * DW;              // |b|^2
  localparam int unsigned QW   = DW + 1;              // quotient bits kept

  localparam logic signed [SW-1:0] SatMax = SW'((64'(1) << (DW - 1)) - 64'(1));
  localparam logic signed [SW-1:0] SatMin = -SatMax - SW'(1);
  localparam logic signed [SW-1:0] BigPos = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] BigNeg = {1'b1, {(SW-1){1'b0}}};

  // Side data that rides alongside the divider lanes.
  typedef struct packed {
    op_e                   op;
    logic signed [SW-1:0]  re;
    logic signed [SW-1:0]  im;
    logic                  neg_re;
    logic                  neg_im;
    logic                  dz;
  } side_t;

  // Global advance: the whole pipe moves when the output can take a word.
  logic en;
  logic out_valid_q;
  assign en         = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  // Stage 1: products, squares, add/sub
  // --------------------------------------------------------------------------
  logic                   v1_q;
  op_e                    op1_q;
  logic signed [PW-1:0]   rr1_q, ii1_q, ri1_q, ir1_q, sr1_q, si1_q;
  logic signed [DW:0]     asr1_q, asi1_q;
  logic signed [DW:0]     asr1_d, asi1_d;

  always_comb begin
    if (req_type_i == OpSub) begin
      asr1_d = (DW+1)'(a_real_i) - (DW+1)'(b_real_i);
      asi1_d = (DW+1)'(a_imag_i) - (DW+1)'(b_imag_i);
    end else begin
      asr1_d = (DW+1)'(a_real_i) + (DW+1)'(b_real_i);
      asi1_d = (DW+1)'(a_imag_i) + (DW+1)'(b_imag_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= req_type_i;
      rr1_q  <= PW'(a_real_i) * PW'(b_real_i);
      ii1_q  <= PW'(a_imag_i) * PW'(b_imag_i);
      ri1_q  <= PW'(a_real_i) * PW'(b_imag_i);
      ir1_q  <= PW'(a_imag_i) * PW'(b_real_i);
      sr1_q  <= PW'(b_real_i) * PW'(b_real_i);
      si1_q  <= PW'(b_imag_i) * PW'(b_imag_i);
      asr1_q <= asr1_d;
      asi1_q <= asi1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: combine products, form divider operands
  // --------------------------------------------------------------------------
  logic                   v2_q;
  side_t                  side2_d, side2_q;
  logic [NW-1:0]          magr2_d, magi2_d, magr2_q, magi2_q;
  logic [DENW-1:0]        den2_d, den2_q;
  logic signed [SW-1:0]   mre_s, mim_s, nre_s, nim_s;
  logic [SW-1:0]          abs_re, abs_im;

  always_comb begin
    mre_s  = SW'(rr1_q) - SW'(ii1_q);
    mim_s  = SW'(ri1_q) + SW'(ir1_q);
    nre_s  = SW'(rr1_q) + SW'(ii1_q);
    nim_s  = SW'(ir1_q) - SW'(ri1_q);
    den2_d = DENW'($unsigned(sr1_q)) + DENW'($unsigned(si1_q));
    abs_re = nre_s[SW-1] ? $unsigned(-nre_s) : $unsigned(nre_s);
    abs_im = nim_s[SW-1] ? $unsigned(-nim_s) : $unsigned(nim_s);
    magr2_d = NW'(abs_re) << FRAC_BITS;
    magi2_d = NW'(abs_im) << FRAC_BITS;

    side2_d.op     = op1_q;
    side2_d.neg_re = nre_s[SW-1];
    side2_d.neg_im = nim_s[SW-1];
    side2_d.dz     = (op1_q == OpDiv) && (den2_d == '0);
    if (op1_q == OpMul) begin
      side2_d.re = mre_s >>> FRAC_BITS;
      side2_d.im = mim_s >>> FRAC_BITS;
    end else begin
      side2_d.re = SW'(asr1_q);
      side2_d.im = SW'(asi1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q <= side2_d;
      magr2_q <= magr2_d;
      magi2_q <= magi2_d;
      den2_q  <= den2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: one lane per result part, side data delayed to match
  // --------------------------------------------------------------------------
  logic [QW-1:0] quo_re, quo_im;
  logic          ovf_re, ovf_im;

  cau_div_lane #(.NW(NW), .DENW(DENW), .QW(QW)) u_div_re (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (magr2_q),
    .den_i (den2_q),
    .quo_o (quo_re),
    .ovf_o (ovf_re)
  );

  cau_div_lane #(.NW(NW), .DENW(DENW), .QW(QW)) u_div_im (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (magi2_q),
    .den_i (den2_q),
    .quo_o (quo_im),
    .ovf_o (ovf_im)
  );

  logic  vd_q   [QW];
  side_t side_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      vd_q[0] <= v2_q;
      for (int i = 1; i < QW; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side2_q;
      for (int i = 1; i < QW; i++) side_q[i] <= side_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: pick the result, apply sign, saturate
  // --------------------------------------------------------------------------
  side_t                 sd;
  logic signed [SW-1:0]  fre, fim;
  logic                  sat_re, sat_im;
  logic signed [DW-1:0]  res_re_d, res_im_d;

  always_comb begin
    sd = side_q[QW-1];
    fre = sd.re;
    fim = sd.im;
    if (sd.op == OpDiv) begin
      if (sd.dz) begin
        fre = '0;
        fim = '0;
      end else begin
        // Quotient past QW bits: force a value beyond range so it clamps.
        if (ovf_re)         fre = sd.neg_re ? BigNeg : BigPos;
        else if (sd.neg_re) fre = -SW'(quo_re);
        else                fre = SW'(quo_re);
        if (ovf_im)         fim = sd.neg_im ? BigNeg : BigPos;
        else if (sd.neg_im) fim = -SW'(quo_im);
        else                fim = SW'(quo_im);
      end
    end

    sat_re = 1'b1;
    if (fre > SatMax)      res_re_d = DW'(SatMax);
    else if (fre < SatMin) res_re_d = DW'(SatMin);
    else begin
      res_re_d = DW'(fre);
      sat_re   = 1'b0;
    end
    sat_im = 1'b1;
    if (fim > SatMax)      res_im_d = DW'(SatMax);
    else if (fim < SatMin) res_im_d = DW'(SatMin);
    else begin
      res_im_d = DW'(fim);
      sat_im   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_real_o <= res_re_d;
      res_imag_o <= res_im_d;
      div_zero_o <= sd.dz;
      sat_flag_o <= sat_re | sat_im;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker: port-level assertions for the complex arithmetic unit
// Bound to the top level; watches the result channel over time.
// ----------------------------------------------------------------------------
module cau_checker #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DataWidthDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [DATA_WIDTH-1:0] res_real_o,
  input logic signed [DATA_WIDTH-1:0] res_imag_o,
  input logic                         div_zero_o,
  input logic                         sat_flag_o
);
  import cau_pkg::*;

  localparam logic signed [DATA_WIDTH-1:0] Max = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] Min = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Hold a stalled result word.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_real_o) &&
      $stable(res_imag_o) && $stable(div_zero_o) && $stable(sat_flag_o))
    else $error("result word changed while stalled");

  // Divide by zero gives a clean zero result.
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |->
      !sat_flag_o && res_real_o == '0 && res_imag_o == '0)
    else $error("divide by zero result not zero");

  // Saturation leaves at least one part at a rail.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sat_flag_o |->
      res_real_o == Max || res_real_o == Min ||
      res_imag_o == Max || res_imag_o == Min)
    else $error("saturation flag without clamped part");

  // An empty output never blocks the input.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused while output empty");

endmodule

bind complex_arith_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for complex_arith_unit
// Drives operand words through the valid/ready input, predicts each result
// in Q8.8 with saturation and divide-by-zero handling, and compares every
// result word in order. A directed table comes first, then random words.
// ----------------------------------------------------------------------------
module tb;
  import cau_pkg::*;

  localparam int unsigned Dw         = DataWidthDef;
  localparam int unsigned Fb         = FracBitsDef;
  localparam int          NumRandom  = 1530;
  localparam int          Latency    = Dw + 4;
  localparam longint      QMax       = (64'sd1 <<< (Dw - 1)) - 1;
  localparam longint      QMin       = -QMax - 1;

  typedef struct packed {
    op_e             op;
    logic [Dw-1:0]   ar;
    logic [Dw-1:0]   ai;
    logic [Dw-1:0]   br;
    logic [Dw-1:0]   bi;
  } cpx_req_t;

  typedef struct packed {
    logic [Dw-1:0] re;
    logic [Dw-1:0] im;
    logic          dz;
    logic          sat;
  } cpx_res_t;

  // one directed row: request plus an optional typed-in result
  typedef struct packed {
    cpx_req_t req;
    logic     has_res;
    cpx_res_t res;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  op_e                  req_type_i;
  logic signed [Dw-1:0] a_real_i, a_imag_i, b_real_i, b_imag_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic signed [Dw-1:0] res_real_o, res_imag_o;
  logic                 div_zero_o, sat_flag_o;

  cpx_res_t pending_res_q[$];
  int       fail_cnt;
  bit       stim_done;
  bit       hold_rx;
  dir_row_t dir_rows[$];
  cpx_res_t typed_res_q[$];
  bit       typed_has_q[$];

  complex_arith_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i,
    .a_real_i, .a_imag_i, .b_real_i, .b_imag_i,
    .out_valid_o, .out_ready_i, .res_real_o, .res_imag_o,
    .div_zero_o, .sat_flag_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("tb NOT OK");
    $finish;
  end

  // clamp one part to the signed range, raising the saturation bit
  function automatic logic [Dw-1:0] clamp_part(input longint v, inout logic sat);
    if (v > QMax) begin
      sat = 1'b1;
      return QMax[Dw-1:0];
    end
    if (v < QMin) begin
      sat = 1'b1;
      return QMin[Dw-1:0];
    end
    return v[Dw-1:0];
  endfunction

  function automatic cpx_res_t complex_result(input cpx_req_t r);
    longint ar, ai, br, bi, re, im, den;
    cpx_res_t o;
    logic sat;
    ar = longint'($signed(r.ar));
    ai = longint'($signed(r.ai));
    br = longint'($signed(r.br));
    bi = longint'($signed(r.bi));
    re = 0;
    im = 0;
    sat = 1'b0;
    o.dz = 1'b0;
    case (r.op)
      OpAdd: begin re = ar + br; im = ai + bi; end
      OpSub: begin re = ar - br; im = ai - bi; end
      OpMul: begin
        // arithmetic shift floors toward minus infinity
        re = (ar * br - ai * bi) >>> Fb;
        im = (ar * bi + ai * br) >>> Fb;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) o.dz = 1'b1;
        else begin
          // SV division truncates toward zero
          re = ((ar * br + ai * bi) <<< Fb) / den;
          im = ((ai * br - ar * bi) <<< Fb) / den;
        end
      end
    endcase
    o.re = clamp_part(re, sat);
    o.im = clamp_part(im, sat);
    o.sat = sat;
    return o;
  endfunction

  function automatic dir_row_t mk_row(input op_e op, input int ar, ai, br, bi,
                                      input bit has, input int re = 0, im = 0,
                                      input bit dz = 0, sat = 0);
    dir_row_t d;
    d.req = '{op, ar[Dw-1:0], ai[Dw-1:0], br[Dw-1:0], bi[Dw-1:0]};
    d.has_res = has;
    d.res = '{re[Dw-1:0], im[Dw-1:0], dz, sat};
    return d;
  endfunction

  function automatic logic [Dw-1:0] rand_part(input int mode);
    case (mode)
      0: return QMax[Dw-1:0];
      1: return QMin[Dw-1:0];
      2: return Dw'($urandom_range(0, 1023) - 512);
      default: return Dw'($urandom);
    endcase
  endfunction

  function automatic cpx_req_t rand_req();
    cpx_req_t r;
    r.op = op_e'($urandom_range(0, 3));
    r.ar = rand_part($urandom_range(0, 7));
    r.ai = rand_part($urandom_range(0, 7));
    r.br = rand_part($urandom_range(0, 7));
    r.bi = rand_part($urandom_range(0, 7));
    if (r.op == OpDiv && $urandom_range(0, 19) == 0) begin
      r.br = '0;
      r.bi = '0;
    end
    return r;
  endfunction

  // drive one word and hold it until accepted
  task automatic send_word(input cpx_req_t r);
    in_valid_i <= 1'b1;
    req_type_i <= r.op;
    a_real_i   <= r.ar;
    a_imag_i   <= r.ai;
    b_real_i   <= r.br;
    b_imag_i   <= r.bi;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_res_q.push_back(complex_result(r));
  endtask

  task automatic drop_valid_for(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // sender: directed table, then bursts of random words with gaps
  initial begin
    int burst;
    in_valid_i  = 1'b0;
    req_type_i  = OpAdd;
    a_real_i    = '0;
    a_imag_i    = '0;
    b_real_i    = '0;
    b_imag_i    = '0;
    out_ready_i = 1'b0;
    rst_ni      = 1'b0;
    fail_cnt    = 0;
    stim_done   = 0;
    hold_rx     = 0;
    dir_rows.push_back(mk_row(OpAdd, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OpAdd, 32767, 32767, 1, 1, 1, 32767, 32767, 0, 1));
    dir_rows.push_back(mk_row(OpAdd, -32768, -32768, -1, -1, 1, -32768, -32768, 0, 1));
    dir_rows.push_back(mk_row(OpAdd, 32767, -32768, 0, 0, 1, 32767, -32768, 0, 0));
    dir_rows.push_back(mk_row(OpSub, -32768, 32767, 1, -1, 1, -32768, 32767, 0, 1));
    dir_rows.push_back(mk_row(OpSub, 256, 512, 256, 256, 1, 0, 256, 0, 0));
    dir_rows.push_back(mk_row(OpMul, 256, 0, 256, 0, 1, 256, 0, 0, 0));
    dir_rows.push_back(mk_row(OpMul, 0, 256, 0, 256, 1, -256, 0, 0, 0));
    dir_rows.push_back(mk_row(OpMul, -1, 0, 1, 0, 1, -1, 0, 0, 0));
    dir_rows.push_back(mk_row(OpMul, 32767, 32767, 32767, 32767, 0));
    dir_rows.push_back(mk_row(OpMul, -32768, -32768, -32768, 32767, 0));
    dir_rows.push_back(mk_row(OpDiv, 256, 256, 0, 0, 1, 0, 0, 1, 0));
    dir_rows.push_back(mk_row(OpDiv, -32768, 32767, 0, 0, 1, 0, 0, 1, 0));
    dir_rows.push_back(mk_row(OpDiv, 512, 0, 256, 0, 1, 512, 0, 0, 0));
    dir_rows.push_back(mk_row(OpDiv, 32767, 0, 1, 0, 1, 32767, 0, 0, 1));
    dir_rows.push_back(mk_row(OpDiv, -32768, -32768, 1, 0, 1, -32768, -32768, 0, 1));
    dir_rows.push_back(mk_row(OpDiv, 0, 256, 0, 256, 1, 256, 0, 0, 0));
    dir_rows.push_back(mk_row(OpDiv, -1, 0, 32767, 0, 0));
    dir_rows.push_back(mk_row(OpDiv, 100, -77, -32768, -32768, 0));
    dir_rows.push_back(mk_row(OpMul, 1, 1, -1, 1, 0));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      typed_has_q.push_back(dir_rows[i].has_res);
      typed_res_q.push_back(dir_rows[i].res);
      send_word(dir_rows[i].req);
    end
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NumRandom; k++, n++) begin
        // long receiver hold-off while words keep coming, to fill the pipe
        if (n == 300) hold_rx = 1;
        // pause until the pipe drains
        if (n == 800) begin
          in_valid_i <= 1'b0;
          while (pending_res_q.size() != 0) @(posedge clk_i);
        end
        send_word(rand_req());
      end
      if ($urandom_range(0, 2) != 0) drop_valid_for($urandom_range(1, 6));
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // receiver: stall pattern of its own, plus one long hold-off
  initial begin
    int hold_cnt;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        for (hold_cnt = 0; hold_cnt < 200; hold_cnt++) @(posedge clk_i);
        hold_rx = 0;
      end
      out_ready_i <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < 10);
    end
  end

  // compare accepted result words against the oldest prediction
  always @(posedge clk_i) begin
    cpx_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_res_q.size() == 0) begin
        $error("result word with nothing expected");
        fail_cnt++;
      end else begin
        exp_res = pending_res_q.pop_front();
        // typed-in rows must also agree with the predictor itself
        if (typed_has_q.size() != 0) begin
          if (typed_has_q[0] && typed_res_q[0] != exp_res) begin
            $error("table row disagrees: expected %h predicted %h",
                   typed_res_q[0], exp_res);
            fail_cnt++;
          end
          void'(typed_has_q.pop_front());
          void'(typed_res_q.pop_front());
        end
        if (res_real_o !== exp_res.re) begin
          $error("res_real expected %h actual %h", exp_res.re, res_real_o);
          fail_cnt++;
        end
        if (res_imag_o !== exp_res.im) begin
          $error("res_imag expected %h actual %h", exp_res.im, res_imag_o);
          fail_cnt++;
        end
        if (div_zero_o !== exp_res.dz) begin
          $error("div_zero expected %b actual %b", exp_res.dz, div_zero_o);
          fail_cnt++;
        end
        if (sat_flag_o !== exp_res.sat) begin
          $error("sat_flag expected %b actual %b", exp_res.sat, sat_flag_o);
          fail_cnt++;
        end
      end
    end
  end

  // end of run: drain, let the pipe settle, report
  initial begin
    wait (stim_done);
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (Latency * 2) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
